[rtl/trp_pkg.sv]
// shared types and constants for the telemetry record parser
`default_nettype none

package trp_pkg;

	// record length rules
	localparam int unsigned FLAGS_LEN    = 6;
	localparam int unsigned TEMP_MIN_LEN = 4;
	localparam int unsigned VOLT_MIN_LEN = 2;
	localparam int unsigned CAPTURE_W    = 8 * FLAGS_LEN;

	// configuration register indexes
	localparam logic [1:0] CFG_COMMAND_CODE = 2'd0;
	localparam logic [1:0] CFG_FLAGS_ID     = 2'd1;
	localparam logic [1:0] CFG_TEMP_ID      = 2'd2;
	localparam logic [1:0] CFG_VOLT_ID      = 2'd3;

	// configuration reset values
	localparam logic [7:0]  RST_COMMAND_CODE = 8'd184;
	localparam logic [15:0] RST_FLAGS_ID     = 16'd61977;
	localparam logic [15:0] RST_TEMP_ID      = 16'd61998;
	localparam logic [15:0] RST_VOLT_ID      = 16'd62030;

	typedef enum logic [2:0] {
		PH_CMD,
		PH_COUNT,
		PH_IDHI,
		PH_IDLO,
		PH_LEN,
		PH_DATA,
		PH_SKIP
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_WRONG = 2'd2,
		ST_TRUNC = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]  command_code;
		logic [15:0] flags_record_id;
		logic [15:0] temp_current_record_id;
		logic [15:0] bus_voltage_record_id;
	} cfg_t;

	typedef struct packed {
		status_t                parse_status;
		logic [7:0]             records_seen;
		logic [CAPTURE_W-1:0]   flag_bits;
		logic [15:0]            temperature;
		logic [15:0]            phase_current;
		logic [15:0]            bus_voltage;
		logic                   telemetry_valid;
	} result_t;

endpackage

`default_nettype wire

[rtl/trp_cfg_regs.sv]
// configuration register file of the telemetry record parser
`default_nettype none

module trp_cfg_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output trp_pkg::cfg_t    cfg
);
	import trp_pkg::*;

	cfg_t cfg_q;

	// register writes, decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.command_code           <= RST_COMMAND_CODE;
			cfg_q.flags_record_id        <= RST_FLAGS_ID;
			cfg_q.temp_current_record_id <= RST_TEMP_ID;
			cfg_q.bus_voltage_record_id  <= RST_VOLT_ID;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COMMAND_CODE: cfg_q.command_code           <= cfg_data[7:0];
				CFG_FLAGS_ID:     cfg_q.flags_record_id        <= cfg_data;
				CFG_TEMP_ID:      cfg_q.temp_current_record_id <= cfg_data;
				CFG_VOLT_ID:      cfg_q.bus_voltage_record_id  <= cfg_data;
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/trp_parser.sv]
// byte-wise record walker with telemetry holding registers
`default_nettype none

module trp_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	input  wire trp_pkg::cfg_t cfg,
	output logic             res_load,
	output trp_pkg::result_t res
);
	import trp_pkg::*;

	phase_t               phase_q, phase_d;
	logic [7:0]           left_q, left_d;
	logic [15:0]          key_q, key_d;
	logic [7:0]           len_q, len_d;
	logic [7:0]           bytes_q, bytes_d;
	logic [CAPTURE_W-1:0] cap_q, cap_d;
	logic [CAPTURE_W-1:0] flags_q, flags_d;
	logic [15:0]          temp_q, temp_d;
	logic [15:0]          cur_q, cur_d;
	logic [15:0]          volt_q, volt_d;
	logic                 tvalid_q, tvalid_d;
	status_t              outcome_q, outcome_d;
	logic [7:0]           tally_q, tally_d;
	logic                 apply;
	status_t              status;

	// next-state logic for one accepted byte
	always_comb begin
		phase_d   = phase_q;
		left_d    = left_q;
		key_d     = key_q;
		len_d     = len_q;
		bytes_d   = bytes_q;
		cap_d     = cap_q;
		flags_d   = flags_q;
		temp_d    = temp_q;
		cur_d     = cur_q;
		volt_d    = volt_q;
		tvalid_d  = tvalid_q;
		outcome_d = outcome_q;
		tally_d   = tally_q;
		apply     = 1'b0;

		unique case (phase_q)
			PH_CMD: begin
				tally_d = '0;
				if (!last_byte) begin
					if (data_byte == cfg.command_code) begin
						phase_d = PH_COUNT;
					end else begin
						outcome_d = ST_WRONG;
						phase_d   = PH_SKIP;
					end
				end
			end
			PH_COUNT: begin
				left_d = data_byte;
				if (data_byte == 8'd0) begin
					outcome_d = ST_OK;
					phase_d   = PH_SKIP;
				end else begin
					phase_d = PH_IDHI;
				end
			end
			PH_IDHI: begin
				key_d   = {data_byte, 8'd0};
				phase_d = PH_IDLO;
			end
			PH_IDLO: begin
				key_d   = {key_q[15:8], data_byte};
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d   = data_byte;
				bytes_d = '0;
				cap_d   = '0;
				if (data_byte == 8'd0) begin
					apply = 1'b1;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				// capture the first six data bytes, first byte on top
				for (int i = 0; i < FLAGS_LEN; i++) begin
					if (bytes_q == 8'(i)) begin
						cap_d[8*(FLAGS_LEN-1-i) +: 8] = data_byte;
					end
				end
				bytes_d = bytes_q + 8'd1;
				if (bytes_d == len_q) begin
					apply = 1'b1;
				end
			end
			PH_SKIP: begin
				phase_d = PH_SKIP;
			end
			default: begin
				phase_d = PH_CMD;
			end
		endcase

		// record complete: update telemetry, then move to the next record or finish the packet
		if (apply) begin
			priority if (key_d == cfg.flags_record_id && len_d == 8'(FLAGS_LEN)) begin
				flags_d  = cap_d;
				tvalid_d = 1'b1;
			end else if (key_d == cfg.temp_current_record_id
					&& len_d >= 8'(TEMP_MIN_LEN)) begin
				temp_d   = cap_d[CAPTURE_W-1 -: 16];
				cur_d    = cap_d[CAPTURE_W-17 -: 16];
				tvalid_d = 1'b1;
			end else if (key_d == cfg.bus_voltage_record_id
					&& len_d >= 8'(VOLT_MIN_LEN)) begin
				volt_d   = cap_d[CAPTURE_W-1 -: 16];
				tvalid_d = 1'b1;
			end else begin
				tvalid_d = tvalid_d;
			end
			tally_d = tally_q + 8'd1;
			left_d  = left_q - 8'd1;
			if (left_d == 8'd0) begin
				outcome_d = ST_OK;
				phase_d   = PH_SKIP;
			end else begin
				phase_d = PH_IDHI;
			end
		end

		// packet end status
		priority if (phase_q == PH_CMD) begin
			status = ST_SHORT;
		end else if (phase_d == PH_SKIP) begin
			status = outcome_d;
		end else begin
			status = ST_TRUNC;
		end
		if (last_byte) begin
			phase_d = PH_CMD;
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_CMD;
			left_q    <= '0;
			key_q     <= '0;
			len_q     <= '0;
			bytes_q   <= '0;
			cap_q     <= '0;
			flags_q   <= '0;
			temp_q    <= '0;
			cur_q     <= '0;
			volt_q    <= '0;
			tvalid_q  <= 1'b0;
			outcome_q <= ST_OK;
			tally_q   <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			left_q    <= left_d;
			key_q     <= key_d;
			len_q     <= len_d;
			bytes_q   <= bytes_d;
			cap_q     <= cap_d;
			flags_q   <= flags_d;
			temp_q    <= temp_d;
			cur_q     <= cur_d;
			volt_q    <= volt_d;
			tvalid_q  <= tvalid_d;
			outcome_q <= outcome_d;
			tally_q   <= tally_d;
		end
	end

	// result for the last byte of a packet
	assign res_load            = step & last_byte;
	assign res.parse_status    = status;
	assign res.records_seen    = tally_d;
	assign res.flag_bits       = flags_d;
	assign res.temperature     = temp_d;
	assign res.phase_current   = cur_d;
	assign res.bus_voltage     = volt_d;
	assign res.telemetry_valid = tvalid_d;

endmodule

`default_nettype wire

[rtl/telemetry_record_parser.sv]
// top level of the telemetry record parser
// Usage:
//   Payload bytes enter on the byte channel (byte_valid, byte_stall, data_byte,
//   last_byte), one per transaction; last_byte marks the final payload byte.
//   One result transaction per packet leaves on the result channel
//   (result_valid, result_stall) with status, record count and telemetry.
//   Configuration registers are written through cfg_we, cfg_index, cfg_data
//   while no packet is in flight.
// Timing:
//   An accepted byte is parsed straight from the input register; a last byte's
//   result enters the output register as that byte is parsed, unless a held
//   result makes it wait. One byte per cycle is sustained while no last byte
//   waits, set by the single parse step between the two registers.
// Reset:
//   arst_n clears the parser, telemetry and the valid flags and restores the
//   default configuration.
// Backpressure:
//   While a result is held under result_stall, ordinary bytes keep flowing;
//   only a last byte waits in the input register, and byte_stall is raised
//   until the held result is taken.
`default_nettype none

module telemetry_record_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [1:0]       parse_status,
	output logic [7:0]       records_seen,
	output logic [47:0]      flag_bits,
	output logic [15:0]      temperature,
	output logic [15:0]      phase_current,
	output logic [15:0]      bus_voltage,
	output logic             telemetry_valid,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import trp_pkg::*;

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       blocked;
	logic       step;
	logic       res_load;
	result_t    res;
	logic       res_valid_q;
	result_t    res_q;

	trp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// a last byte must wait while the output register is held
	assign blocked    = last_s1 & res_valid_q & result_stall;
	assign byte_stall = valid_s1 & blocked;
	assign step       = valid_s1 & ~blocked;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	trp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.cfg       (cfg),
		.res_load  (res_load),
		.res       (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign result_valid    = res_valid_q;
	assign parse_status    = res_q.parse_status;
	assign records_seen    = res_q.records_seen;
	assign flag_bits       = res_q.flag_bits;
	assign temperature     = res_q.temperature;
	assign phase_current   = res_q.phase_current;
	assign bus_voltage     = res_q.bus_voltage;
	assign telemetry_valid = res_q.telemetry_valid;

	// a new result only comes from a parsed last byte
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(step && last_s1))
		else $error("result appeared without a parsed last byte");

	// short or wrong-command packets walk no records
	a_no_records: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.parse_status == ST_SHORT
			|| res_q.parse_status == ST_WRONG)) |-> (res_q.records_seen == 8'd0))
		else $error("records counted in a rejected packet");

	// input stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (res_valid_q && result_stall && last_s1))
		else $error("byte channel stalled without a held result");

endmodule

`default_nettype wire

[verif/tb_telemetry_record_parser.sv]
// self-checking testbench for the telemetry record parser
import trp_pkg::*;

// tracks the parser state and holds the reports each packet must produce
class telemetry_tracker;
	logic [7:0]  cmd_code;
	logic [15:0] flags_id;
	logic [15:0] temp_id;
	logic [15:0] volt_id;

	phase_t      phase;
	status_t     outcome;
	logic [7:0]  remaining;
	logic [15:0] rec_id;
	logic [7:0]  rec_len;
	logic [7:0]  data_count;
	logic [47:0] capture;
	logic [47:0] flags;
	logic [15:0] temp;
	logic [15:0] current;
	logic [15:0] volt;
	logic        tele_valid;
	logic [7:0]  tally;

	result_t     expected_reports[$];
	int          mismatches;

	function new();
		cmd_code   = RST_COMMAND_CODE;
		flags_id   = RST_FLAGS_ID;
		temp_id    = RST_TEMP_ID;
		volt_id    = RST_VOLT_ID;
		phase      = PH_CMD;
		outcome    = ST_OK;
		remaining  = '0;
		rec_id     = '0;
		rec_len    = '0;
		data_count = '0;
		capture    = '0;
		flags      = '0;
		temp       = '0;
		current    = '0;
		volt       = '0;
		tele_valid = 1'b0;
		tally      = '0;
		mismatches = 0;
	endfunction

	function void set_register(logic [1:0] idx, logic [15:0] value);
		case (idx)
			CFG_COMMAND_CODE: cmd_code = value[7:0];
			CFG_FLAGS_ID:     flags_id = value;
			CFG_TEMP_ID:      temp_id  = value;
			CFG_VOLT_ID:      volt_id  = value;
			default: ;
		endcase
	endfunction

	// apply a finished record, first matching rule wins
	function void close_record();
		if (rec_id == flags_id && rec_len == FLAGS_LEN) begin
			flags      = capture;
			tele_valid = 1'b1;
		end else if (rec_id == temp_id && rec_len >= TEMP_MIN_LEN) begin
			temp       = capture[47:32];
			current    = capture[31:16];
			tele_valid = 1'b1;
		end else if (rec_id == volt_id && rec_len >= VOLT_MIN_LEN) begin
			volt       = capture[47:32];
			tele_valid = 1'b1;
		end
		tally     = tally + 8'd1;
		remaining = remaining - 8'd1;
		if (remaining == 8'd0) begin
			outcome = ST_OK;
			phase   = PH_SKIP;
		end else begin
			phase = PH_IDHI;
		end
	endfunction

	// one accepted byte transaction
	function void absorb_byte(logic [7:0] b, logic last);
		logic    at_cmd;
		result_t report;
		at_cmd = (phase == PH_CMD);
		case (phase)
			PH_CMD: begin
				tally = '0;
				if (!last) begin
					if (b == cmd_code) begin
						phase = PH_COUNT;
					end else begin
						outcome = ST_WRONG;
						phase   = PH_SKIP;
					end
				end
			end
			PH_COUNT: begin
				remaining = b;
				if (b == 8'd0) begin
					outcome = ST_OK;
					phase   = PH_SKIP;
				end else begin
					phase = PH_IDHI;
				end
			end
			PH_IDHI: begin
				rec_id = {b, 8'h00};
				phase  = PH_IDLO;
			end
			PH_IDLO: begin
				rec_id[7:0] = b;
				phase       = PH_LEN;
			end
			PH_LEN: begin
				rec_len    = b;
				data_count = '0;
				capture    = '0;
				if (b == 8'd0) close_record();
				else phase = PH_DATA;
			end
			PH_DATA: begin
				if (data_count < FLAGS_LEN)
					capture[8 * (FLAGS_LEN - 1 - data_count) +: 8] = b;
				data_count = data_count + 8'd1;
				if (data_count == rec_len) close_record();
			end
			default: ;
		endcase

		if (last) begin
			if (at_cmd) report.parse_status = ST_SHORT;
			else if (phase == PH_SKIP) report.parse_status = outcome;
			else report.parse_status = ST_TRUNC;
			phase = PH_CMD;
			report.records_seen    = tally;
			report.flag_bits       = flags;
			report.temperature     = temp;
			report.phase_current   = current;
			report.bus_voltage     = volt;
			report.telemetry_valid = tele_valid;
			expected_reports.push_back(report);
		end
	endfunction

	function void compare_field(string name, logic [47:0] want, logic [47:0] seen);
		if (seen !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
			mismatches++;
		end
	endfunction

	// one accepted result transaction
	function void check_report(result_t got);
		result_t want;
		if (expected_reports.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual status %0h seen %0h",
				$time, got.parse_status, got.records_seen);
			mismatches++;
			return;
		end
		want = expected_reports.pop_front();
		compare_field("parse_status", want.parse_status, got.parse_status);
		compare_field("records_seen", want.records_seen, got.records_seen);
		compare_field("flag_bits", want.flag_bits, got.flag_bits);
		compare_field("temperature", want.temperature, got.temperature);
		compare_field("phase_current", want.phase_current, got.phase_current);
		compare_field("bus_voltage", want.bus_voltage, got.bus_voltage);
		compare_field("telemetry_valid", want.telemetry_valid, got.telemetry_valid);
	endfunction
endclass

module tb_telemetry_record_parser;

	localparam int STUCK_LIMIT = 2000;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 4;
	localparam int TAIL        = 8;
	localparam int PHASE_BYTES = 120;
	localparam int PHASES      = 8;

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        result_valid;
	logic        result_stall;
	logic [1:0]  parse_status;
	logic [7:0]  records_seen;
	logic [47:0] flag_bits;
	logic [15:0] temperature;
	logic [15:0] phase_current;
	logic [15:0] bus_voltage;
	logic        telemetry_valid;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	telemetry_tracker tracker = new();
	cfg_t             cur_cfg;
	logic [7:0]       pkt_bytes[$];
	result_t          seen_report;
	bit               sender_gaps;
	bit               rx_quiet;
	bit               hold_request;
	int               phase_bytes;

	wire traffic = (byte_valid && !byte_stall) || (result_valid && !result_stall);

	telemetry_record_parser dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.data_byte       (data_byte),
		.last_byte       (last_byte),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.parse_status    (parse_status),
		.records_seen    (records_seen),
		.flag_bits       (flag_bits),
		.temperature     (temperature),
		.phase_current   (phase_current),
		.bus_voltage     (bus_voltage),
		.telemetry_valid (telemetry_valid),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// observe both channels at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				seen_report.parse_status    = status_t'(parse_status);
				seen_report.records_seen    = records_seen;
				seen_report.flag_bits       = flag_bits;
				seen_report.temperature     = temperature;
				seen_report.phase_current   = phase_current;
				seen_report.bus_voltage     = bus_voltage;
				seen_report.telemetry_valid = telemetry_valid;
				tracker.check_report(seen_report);
			end
			if (byte_valid && !byte_stall)
				tracker.absorb_byte(data_byte, last_byte);
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if (traffic) stuck = 0;
			else stuck++;
		end
		$display("** telemetry_record_parser: FAILED **");
		$finish;
	end

	// result side stall pattern
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				result_stall <= 1'b0;
			end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				result_stall <= 1'b0;
			end else begin
				result_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	task automatic send_byte(logic [7:0] b, logic last);
		byte_valid <= 1'b1;
		data_byte  <= b;
		last_byte  <= last;
		do @(posedge clk); while (byte_stall);
	endtask

	task automatic idle_sender(int cycles);
		byte_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic send_packet();
		foreach (pkt_bytes[i]) begin
			if (sender_gaps && $urandom_range(0, 5) == 0)
				idle_sender($urandom_range(1, 17));
			send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
		end
		phase_bytes += pkt_bytes.size();
	endtask

	// hold the byte channel until every outstanding report is back
	task automatic wait_reports_done();
		byte_valid <= 1'b0;
		do @(posedge clk); while (tracker.expected_reports.size() != 0);
	endtask

	task automatic put_reg(logic [1:0] idx, logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		tracker.set_register(idx, value);
	endtask

	task automatic program_config(cfg_t c);
		put_reg(CFG_COMMAND_CODE, {8'h00, c.command_code});
		put_reg(CFG_FLAGS_ID, c.flags_record_id);
		put_reg(CFG_TEMP_ID, c.temp_current_record_id);
		put_reg(CFG_VOLT_ID, c.bus_voltage_record_id);
		cfg_we  <= 1'b0;
		cur_cfg  = c;
	endtask

	task automatic add_random_record();
		logic [15:0] id;
		logic [7:0]  len;
		case ($urandom_range(0, 3))
			0: id = cur_cfg.flags_record_id;
			1: id = cur_cfg.temp_current_record_id;
			2: id = cur_cfg.bus_voltage_record_id;
			default: id = 16'($urandom_range(0, 65535));
		endcase
		if ($urandom_range(0, 39) == 0) len = 8'($urandom_range(7, 40));
		else if (id == cur_cfg.flags_record_id && $urandom_range(0, 3) != 0)
			len = 8'(FLAGS_LEN);
		else len = 8'($urandom_range(0, 9));
		pkt_bytes.push_back(id[15:8]);
		pkt_bytes.push_back(id[7:0]);
		pkt_bytes.push_back(len);
		repeat (len) pkt_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// mostly well-formed packets, some cut short, wrong command or noise
	task automatic build_random_packet();
		int         kind;
		int         count;
		int         cut;
		logic [7:0] first;
		pkt_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			count = ($urandom_range(0, 9) == 0 && kind < 70) ? 0 : $urandom_range(1, 4);
			pkt_bytes.push_back(cur_cfg.command_code);
			pkt_bytes.push_back(8'(count));
			repeat (count) add_random_record();
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
			if (kind >= 70) begin
				// truncated: claim more records, or drop the tail
				if ($urandom_range(0, 1) == 0) begin
					pkt_bytes[1] = 8'(count + $urandom_range(1, 200));
				end else begin
					cut = $urandom_range(3, pkt_bytes.size() - 1);
					while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
				end
			end
		end else if (kind < 93) begin
			first = 8'($urandom_range(0, 255));
			if (first == cur_cfg.command_code) first = first + 8'd1;
			pkt_bytes.push_back(first);
			repeat ($urandom_range(0, 5)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			pkt_bytes.push_back($urandom_range(0, 1) ? cur_cfg.command_code
				: 8'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 7)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		cfg_t next_cfg;
		logic [15:0] shared_id;
		arst_n       = 1'b0;
		byte_valid   = 1'b0;
		data_byte    = '0;
		last_byte    = 1'b0;
		result_stall = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		sender_gaps  = 1'b1;
		rx_quiet     = 1'b0;
		hold_request = 1'b0;
		phase_bytes  = 0;
		cur_cfg      = '{RST_COMMAND_CODE, RST_FLAGS_ID, RST_TEMP_ID, RST_VOLT_ID};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed packets under the reset configuration
		// one-byte packet with the right command
		pkt_bytes = '{RST_COMMAND_CODE};
		send_packet();
		// one-byte packet with a wrong command: short wins
		pkt_bytes = '{8'h00};
		send_packet();
		// wrong command, rest ignored
		pkt_bytes = '{8'hFF, RST_COMMAND_CODE, 8'h00};
		send_packet();
		// zero record count with trailing bytes
		pkt_bytes = '{RST_COMMAND_CODE, 8'h00, 8'hFF};
		send_packet();
		// flags record then a zero-length record
		pkt_bytes = '{RST_COMMAND_CODE, 8'h02, RST_FLAGS_ID[15:8], RST_FLAGS_ID[7:0], 8'h06,
			8'hFF, 8'h00, 8'h80, 8'h01, 8'h7E, 8'hA5, 8'h00, 8'h00, 8'h00};
		send_packet();
		// temperature record with data past the capture window
		pkt_bytes = '{RST_COMMAND_CODE, 8'h01, RST_TEMP_ID[15:8], RST_TEMP_ID[7:0], 8'h08,
			8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE, 8'hF0};
		send_packet();
		// bus voltage record, then the packet ends inside the next record
		pkt_bytes = '{RST_COMMAND_CODE, 8'h03, RST_VOLT_ID[15:8], RST_VOLT_ID[7:0], 8'h02,
			8'hAB, 8'hCD, RST_VOLT_ID[15:8], RST_VOLT_ID[7:0], 8'h05, 8'h01};
		send_packet();

		// random phases, each under its own configuration
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_reports_done();
			repeat (SETTLE) @(posedge clk);
			next_cfg.command_code           = 8'($urandom_range(0, 255));
			next_cfg.flags_record_id        = 16'($urandom_range(0, 65535));
			next_cfg.temp_current_record_id = 16'($urandom_range(0, 65535));
			next_cfg.bus_voltage_record_id  = 16'($urandom_range(0, 65535));
			shared_id = 16'($urandom_range(0, 65535));
			case (ph)
				0: next_cfg = '{8'h00, 16'h0000, 16'h0000, 16'h0000};
				1: next_cfg = '{8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
				3: next_cfg = '{RST_COMMAND_CODE, RST_FLAGS_ID, RST_TEMP_ID, RST_VOLT_ID};
				4: begin
					next_cfg.flags_record_id        = shared_id;
					next_cfg.temp_current_record_id = shared_id;
					next_cfg.bus_voltage_record_id  = shared_id;
				end
				6: next_cfg.bus_voltage_record_id = next_cfg.temp_current_record_id;
				default: ;
			endcase
			program_config(next_cfg);

			// long result hold-off with a gapless sender, and a quiet last phase
			sender_gaps  = (ph != 3) && (ph != PHASES - 1);
			rx_quiet     = (ph == PHASES - 1);
			hold_request = (ph == 3);
			phase_bytes  = 0;
			while (phase_bytes < PHASE_BYTES) begin
				build_random_packet();
				send_packet();
				if (ph != PHASES - 1 && $urandom_range(0, 24) == 0)
					wait_reports_done();
			end
		end

		wait_reports_done();
		repeat (TAIL) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.expected_reports.size() == 0)
			$display("** telemetry_record_parser: PASSED **");
		else
			$display("** telemetry_record_parser: FAILED **");
		$finish;
	end

endmodule
